// ===== hdl/first_fit_segment_allocator_macros.svh =====
// Assertion macros used by the allocator module.
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH

// Check an expression at every rising clock edge outside reset.
`define FFSA_CHECK(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check an expression in the cycle after a condition.
`define FFSA_CHECK_NEXT(lbl, cond, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) else $error(msg);

`endif

// ===== hdl/ffsa_pkg.sv =====
package ffsa_pkg;

	localparam int MAX_SEGMENTS = 16;
	localparam int MAX_ALLOCS   = 32;
	localparam int HEADER_BYTES = 8;
	localparam int ADDR_W       = 32;
	localparam int LEN_W        = 32;
	localparam int ALIGN_W      = 3;
	localparam int ADJ_W        = 9;
	localparam int REC_ADJ_W    = 8;
	localparam int STATUS_W     = 2;
	localparam int SEG_IW       = $clog2(MAX_SEGMENTS);
	localparam int SEG_CW       = $clog2(MAX_SEGMENTS + 1);
	localparam int REC_IW       = (MAX_ALLOCS > 1) ? $clog2(MAX_ALLOCS) : 1;
	localparam int LIVE_W       = 6;
	localparam int CFG_IW       = 2;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [LEN_W-1:0] len_t;
	typedef logic [ADJ_W-1:0] adj_t;
	typedef logic [ALIGN_W-1:0] align_t;
	typedef logic [SEG_IW-1:0] seg_idx_t;
	typedef logic [SEG_CW-1:0] seg_cnt_t;
	typedef logic [LIVE_W-1:0] live_t;
	typedef logic [CFG_IW-1:0] cfg_idx_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_NOFIT   = 2'd1,
		STAT_UNKNOWN = 2'd2,
		STAT_FULL    = 2'd3
	} status_t;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam cfg_idx_t REG_POOL_BASE  = 2'd0;
	localparam cfg_idx_t REG_POOL_BYTES = 2'd1;

	typedef struct packed {
		logic     we;
		seg_idx_t idx;
		addr_t    start;
		len_t     length;
	} seg_wr_t;

	typedef struct packed {
		logic  fits;
		logic  absorb;
		adj_t  adj;
		len_t  total;
		len_t  rem;
		addr_t granted;
		addr_t new_start;
	} fit_t;

endpackage

// ===== hdl/ffsa_if.sv =====
interface ffsa_req_if;
	logic                   valid;
	logic                   ready;
	logic                   op;
	ffsa_pkg::len_t         req_size;
	ffsa_pkg::align_t       align_log2;
	ffsa_pkg::addr_t        free_address;
	modport source (output valid, op, req_size, align_log2, free_address, input ready);
	modport sink (input valid, op, req_size, align_log2, free_address, output ready);
endinterface

interface ffsa_rsp_if;
	logic                   valid;
	logic                   ready;
	ffsa_pkg::addr_t        granted_address;
	ffsa_pkg::status_t      status;
	ffsa_pkg::len_t         bytes_in_use;
	ffsa_pkg::live_t        live_count;
	modport source (output valid, granted_address, status, bytes_in_use, live_count,
		input ready);
	modport sink (input valid, granted_address, status, bytes_in_use, live_count,
		output ready);
endinterface

interface ffsa_cfg_if;
	logic                   valid;
	logic                   ready;
	ffsa_pkg::cfg_idx_t     index;
	logic [31:0]            data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/ffsa_fit.sv =====
module ffsa_fit (
	input  ffsa_pkg::addr_t  seg_start,
	input  ffsa_pkg::len_t   seg_len,
	input  ffsa_pkg::len_t   req_size,
	input  ffsa_pkg::align_t align_log2,
	output ffsa_pkg::fit_t   fit
);
	import ffsa_pkg::*;

	adj_t           al_m1;
	adj_t           adj0;
	adj_t           need;
	adj_t           up;
	adj_t           adj;
	logic [LEN_W:0] total_w;

	always_comb begin
		al_m1 = (ADJ_W'(1) << align_log2) - ADJ_W'(1);
		adj0  = (ADJ_W'(~seg_start[ADJ_W-1:0]) + ADJ_W'(1)) & al_m1;
		need  = ADJ_W'(HEADER_BYTES) - adj0;
		up    = ((need + al_m1) >> align_log2) << align_log2;
		adj   = (adj0 < ADJ_W'(HEADER_BYTES)) ? adj0 + up : adj0;
		total_w = {1'b0, req_size} + (LEN_W+1)'(adj);
		fit.adj       = adj;
		fit.total     = total_w[LEN_W-1:0];
		fit.fits      = {1'b0, seg_len} >= total_w;
		fit.rem       = seg_len - total_w[LEN_W-1:0];
		fit.absorb    = fit.rem <= LEN_W'(HEADER_BYTES);
		fit.granted   = seg_start + ADDR_W'(adj);
		fit.new_start = seg_start + ADDR_W'(total_w[LEN_W-1:0]);
	end
endmodule

// ===== hdl/ffsa_seg_table.sv =====
module ffsa_seg_table (
	input  logic                clk,
	input  ffsa_pkg::seg_wr_t   wr,
	input  ffsa_pkg::seg_idx_t  rd_idx,
	output ffsa_pkg::addr_t     rd_start,
	output ffsa_pkg::len_t      rd_len
);
	import ffsa_pkg::*;

	addr_t start_q [MAX_SEGMENTS];
	len_t  len_q   [MAX_SEGMENTS];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			start_q[wr.idx] <= wr.start;
			len_q[wr.idx]   <= wr.length;
		end
	end

	assign rd_start = start_q[rd_idx];
	assign rd_len   = len_q[rd_idx];
endmodule

// ===== hdl/first_fit_segment_allocator.sv =====
// Channel | Dir | Transfer carries
// cfg     | in  | index, data (pool_base / pool_bytes)
// req     | in  | op, req_size, align_log2, free_address
// rsp     | out | granted_address, status, bytes_in_use, live_count
// An allocate scans the segments in order until one fits; a rejected request
// goes straight to done. Absorbing a whole segment moves the later entries down.
// A free scans the records for its address, then the segments for its place,
// then merges, and moves entries up to insert a new segment or down when it joins two.
// req.ready is high only while no item is at work; rsp holds its result until taken.
// Reset leaves an empty pool; a pool_base or pool_bytes write leaves one free segment spanning the pool, none if empty.
module first_fit_segment_allocator (
	input logic        clk,
	input logic        arst_n,
	ffsa_cfg_if.sink   cfg,
	ffsa_req_if.sink   req,
	ffsa_rsp_if.source rsp
);
	import ffsa_pkg::*;
	`include "first_fit_segment_allocator_macros.svh"

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_SSCAN    = 8'b0000_0010,
		ST_SHIFT_DN = 8'b0000_0100,
		ST_RSCAN    = 8'b0000_1000,
		ST_PSCAN    = 8'b0001_0000,
		ST_MERGE    = 8'b0010_0000,
		ST_SHIFT_UP = 8'b0100_0000,
		ST_DONE     = 8'b1000_0000
	} state_t;

	state_t   state_q;
	addr_t    pool_base_q;
	len_t     pool_bytes_q;
	seg_cnt_t seg_count_q;
	len_t     used_q;
	live_t    alloc_q;

	addr_t                 rec_addr_q [MAX_ALLOCS];
	len_t                  rec_len_q  [MAX_ALLOCS];
	logic [REC_ADJ_W-1:0]  rec_adj_q  [MAX_ALLOCS];
	logic [MAX_ALLOCS-1:0] rec_valid_q;

	len_t        size_q;
	align_t      align_q;
	addr_t       addr_q;
	logic [REC_IW-1:0] slot_q;
	logic [REC_IW-1:0] rcur_q;
	seg_cnt_t    idx_q;
	seg_cnt_t    cur_q;
	status_t     status_q;
	addr_t       granted_q;
	addr_t       f_start_q;
	len_t        f_size_q;
	addr_t       f_end_q;
	addr_t       prev_end_q;
	len_t        prev_len_q;

	logic        out_valid_q;
	addr_t       out_granted_q;
	status_t     out_status_q;
	len_t        out_used_q;
	live_t       out_live_q;

	seg_wr_t     seg_wr;
	seg_idx_t    rd_idx;
	addr_t       rd_start;
	len_t        rd_len;
	fit_t        fit;
	logic [REC_IW-1:0] free_slot;
	logic        any_free;
	logic        cfg_hit;
	logic        req_fire;
	logic        out_load;
	logic        rec_hit;
	addr_t       r_start;
	logic        mprev;
	logic        mnext;
	logic        commit;
	logic        rec_we;
	len_t        rec_total;
	logic        pscan_stop;

	ffsa_seg_table u_seg (
		.clk      (clk),
		.wr       (seg_wr),
		.rd_idx   (rd_idx),
		.rd_start (rd_start),
		.rd_len   (rd_len)
	);

	ffsa_fit u_fit (
		.seg_start  (rd_start),
		.seg_len    (rd_len),
		.req_size   (size_q),
		.align_log2 (align_q),
		.fit        (fit)
	);

	assign cfg.ready = 1'b1;
	assign cfg_hit   = cfg.valid && (cfg.index == REG_POOL_BASE || cfg.index == REG_POOL_BYTES);
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	always_comb begin
		free_slot = '0;
		for (int i = MAX_ALLOCS - 1; i >= 0; i--) begin
			if (!rec_valid_q[i]) free_slot = REC_IW'(i);
		end
		any_free = ~&rec_valid_q;
	end

	assign rec_hit  = rec_valid_q[rcur_q] && (rec_addr_q[rcur_q] == addr_q);
	assign r_start  = addr_q - ADDR_W'(rec_adj_q[rcur_q]);
	assign mprev    = (idx_q != '0) && (prev_end_q == f_start_q);
	assign mnext    = (idx_q < seg_count_q) && (rd_start == f_end_q);
	assign rec_total = fit.absorb ? rd_len : fit.total;
	assign rec_we   = (state_q == ST_SSCAN) && fit.fits;
	assign pscan_stop = (idx_q >= seg_count_q) || (rd_start >= f_end_q);

	always_comb begin
		rd_idx = idx_q[SEG_IW-1:0];
		unique case (state_q)
			ST_SHIFT_DN: rd_idx = SEG_IW'(cur_q + SEG_CW'(1));
			ST_SHIFT_UP: rd_idx = SEG_IW'(cur_q - SEG_CW'(1));
			default:     rd_idx = idx_q[SEG_IW-1:0];
		endcase
	end

	always_comb begin
		seg_wr = '0;
		commit = 1'b0;
		if (cfg_hit) begin
			seg_wr.we     = 1'b1;
			seg_wr.start  = (cfg.index == REG_POOL_BASE) ? cfg.data : pool_base_q;
			seg_wr.length = (cfg.index == REG_POOL_BYTES) ? cfg.data : pool_bytes_q;
		end else begin
			unique case (state_q)
				ST_SSCAN: begin
					if (fit.fits && !fit.absorb) begin
						seg_wr.we     = 1'b1;
						seg_wr.idx    = idx_q[SEG_IW-1:0];
						seg_wr.start  = fit.new_start;
						seg_wr.length = fit.rem;
					end
				end
				ST_SHIFT_DN: begin
					if (cur_q + SEG_CW'(1) < seg_count_q) begin
						seg_wr.we     = 1'b1;
						seg_wr.idx    = cur_q[SEG_IW-1:0];
						seg_wr.start  = rd_start;
						seg_wr.length = rd_len;
					end
				end
				ST_MERGE: begin
					if (mprev) begin
						seg_wr.we     = 1'b1;
						seg_wr.idx    = SEG_IW'(idx_q - SEG_CW'(1));
						seg_wr.start  = prev_end_q - ADDR_W'(prev_len_q);
						seg_wr.length = mnext ? prev_len_q + f_size_q + rd_len
							: prev_len_q + f_size_q;
						commit = 1'b1;
					end else if (mnext) begin
						seg_wr.we     = 1'b1;
						seg_wr.idx    = idx_q[SEG_IW-1:0];
						seg_wr.start  = f_start_q;
						seg_wr.length = rd_len + f_size_q;
						commit = 1'b1;
					end
				end
				ST_SHIFT_UP: begin
					seg_wr.we  = 1'b1;
					seg_wr.idx = cur_q[SEG_IW-1:0];
					if (cur_q > idx_q) begin
						seg_wr.start  = rd_start;
						seg_wr.length = rd_len;
					end else begin
						seg_wr.start  = f_start_q;
						seg_wr.length = f_size_q;
						commit = 1'b1;
					end
				end
				default: seg_wr = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rec_we) begin
			rec_addr_q[slot_q] <= fit.granted;
			rec_len_q[slot_q]  <= rec_total;
			rec_adj_q[slot_q]  <= fit.adj[REC_ADJ_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			size_q  <= req.req_size;
			align_q <= req.align_log2;
			addr_q  <= req.free_address;
		end
		if (state_q == ST_RSCAN && rec_hit) begin
			f_start_q <= r_start;
			f_size_q  <= rec_len_q[rcur_q];
			f_end_q   <= r_start + rec_len_q[rcur_q];
		end
		if (state_q == ST_PSCAN && !pscan_stop) begin
			prev_end_q <= rd_start + rd_len;
			prev_len_q <= rd_len;
		end
		if (out_load) begin
			out_granted_q <= (status_q == STAT_OK) ? granted_q : '0;
			out_status_q  <= status_q;
			out_used_q    <= used_q;
			out_live_q    <= alloc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pool_base_q  <= '0;
			pool_bytes_q <= '0;
			seg_count_q  <= '0;
			used_q       <= '0;
			alloc_q      <= '0;
			rec_valid_q  <= '0;
			slot_q       <= '0;
			rcur_q       <= '0;
			idx_q        <= '0;
			cur_q        <= '0;
			status_q     <= STAT_OK;
			granted_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_hit) begin
				if (cfg.index == REG_POOL_BASE) pool_base_q <= cfg.data;
				else pool_bytes_q <= cfg.data;
				seg_count_q <= ((cfg.index == REG_POOL_BYTES) ? cfg.data : pool_bytes_q) != '0
					? SEG_CW'(1) : SEG_CW'(0);
				rec_valid_q <= '0;
				used_q      <= '0;
				alloc_q     <= '0;
			end
			if (rec_we) begin
				rec_valid_q[slot_q] <= 1'b1;
				used_q    <= used_q + rec_total;
				alloc_q   <= alloc_q + LIVE_W'(1);
				granted_q <= fit.granted;
				status_q  <= STAT_OK;
			end
			if (commit) begin
				rec_valid_q[slot_q] <= 1'b0;
				used_q    <= used_q - f_size_q;
				if (alloc_q != '0) alloc_q <= alloc_q - LIVE_W'(1);
				granted_q <= '0;
				status_q  <= STAT_OK;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						idx_q  <= '0;
						rcur_q <= '0;
						if (req.op == OP_FREE) begin
							state_q <= ST_RSCAN;
						end else if (req.req_size == '0) begin
							status_q <= STAT_NOFIT;
							state_q  <= ST_DONE;
						end else if (!any_free) begin
							status_q <= STAT_FULL;
							state_q  <= ST_DONE;
						end else if (seg_count_q == '0) begin
							status_q <= STAT_NOFIT;
							state_q  <= ST_DONE;
						end else begin
							slot_q  <= free_slot;
							state_q <= ST_SSCAN;
						end
					end
				end
				ST_SSCAN: begin
					if (fit.fits) begin
						cur_q   <= idx_q;
						state_q <= fit.absorb ? ST_SHIFT_DN : ST_DONE;
					end else if (idx_q + SEG_CW'(1) >= seg_count_q) begin
						status_q <= STAT_NOFIT;
						state_q  <= ST_DONE;
					end else begin
						idx_q <= idx_q + SEG_CW'(1);
					end
				end
				ST_SHIFT_DN: begin
					if (cur_q + SEG_CW'(1) < seg_count_q) begin
						cur_q <= cur_q + SEG_CW'(1);
					end else begin
						seg_count_q <= seg_count_q - SEG_CW'(1);
						state_q     <= ST_DONE;
					end
				end
				ST_RSCAN: begin
					if (rec_hit) begin
						slot_q  <= rcur_q;
						state_q <= ST_PSCAN;
					end else if (rcur_q == REC_IW'(MAX_ALLOCS - 1)) begin
						status_q <= STAT_UNKNOWN;
						state_q  <= ST_DONE;
					end else begin
						rcur_q <= rcur_q + REC_IW'(1);
					end
				end
				ST_PSCAN: begin
					if (pscan_stop) begin
						state_q <= ST_MERGE;
					end else begin
						idx_q <= idx_q + SEG_CW'(1);
					end
				end
				ST_MERGE: begin
					if (mprev && mnext) begin
						cur_q   <= idx_q;
						state_q <= ST_SHIFT_DN;
					end else if (mprev || mnext) begin
						state_q <= ST_DONE;
					end else if (seg_count_q >= SEG_CW'(MAX_SEGMENTS)) begin
						status_q <= STAT_FULL;
						state_q  <= ST_DONE;
					end else begin
						cur_q   <= seg_count_q;
						state_q <= ST_SHIFT_UP;
					end
				end
				ST_SHIFT_UP: begin
					if (cur_q > idx_q) begin
						cur_q <= cur_q - SEG_CW'(1);
					end else begin
						seg_count_q <= seg_count_q + SEG_CW'(1);
						state_q     <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.granted_address = out_granted_q;
	assign rsp.status          = out_status_q;
	assign rsp.bytes_in_use    = out_used_q;
	assign rsp.live_count      = out_live_q;

	`FFSA_CHECK(a_seg_count_max, seg_count_q <= SEG_CW'(MAX_SEGMENTS), "segment count overflow")
	`FFSA_CHECK(a_live_matches, 32'(alloc_q) == 32'($countones(rec_valid_q)), "live count drift")
	`FFSA_CHECK_NEXT(a_busy_after_accept, req_fire, state_q != ST_IDLE, "idle after accept")
	`FFSA_CHECK_NEXT(a_ok_grant, out_load && status_q != STAT_OK, rsp.granted_address == '0,
		"grant on failure")
endmodule

// ===== tb/first_fit_segment_allocator_test.sv =====
module first_fit_segment_allocator_test;
	import ffsa_pkg::*;

	class alloc_scoreboard;
		typedef struct packed {
			addr_t   granted;
			status_t status;
			len_t    used;
			live_t   live;
		} outcome_t;

		outcome_t outcome_q[$];
		int       errors;

		logic [31:0] base;
		logic [31:0] bytes;
		logic [31:0] seg_s[MAX_SEGMENTS];
		logic [31:0] seg_l[MAX_SEGMENTS];
		int          seg_n;
		logic [31:0] rec_addr[MAX_ALLOCS];
		logic [31:0] rec_len[MAX_ALLOCS];
		logic [7:0]  rec_adj[MAX_ALLOCS];
		bit          rec_live[MAX_ALLOCS];
		logic [31:0] used_bytes;
		int          live_n;

		function new();
			errors = 0;
			base = '0;
			bytes = '0;
			clear_pool();
		endfunction

		function void clear_pool();
			foreach (rec_live[i])
				rec_live[i] = 1'b0;
			seg_s[0] = base;
			seg_l[0] = bytes;
			seg_n = (bytes != 0) ? 1 : 0;
			used_bytes = '0;
			live_n = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [31:0] data);
			if (idx == REG_POOL_BASE) begin
				base = data;
				clear_pool();
			end else if (idx == REG_POOL_BYTES) begin
				bytes = data;
				clear_pool();
			end
		endfunction

		function int pending();
			return outcome_q.size();
		endfunction

		function bit pick_live(output logic [31:0] addr);
			int idx_q[$];
			foreach (rec_live[i])
				if (rec_live[i])
					idx_q.push_back(i);
			addr = '0;
			if (idx_q.size() == 0)
				return 1'b0;
			addr = rec_addr[idx_q[$urandom_range(0, idx_q.size() - 1)]];
			return 1'b1;
		endfunction

		function void drop_segment(int p);
			for (int i = p; i + 1 < seg_n; i++) begin
				seg_s[i] = seg_s[i + 1];
				seg_l[i] = seg_l[i + 1];
			end
			if (seg_n > 0)
				seg_n--;
		endfunction

		function status_t grant(logic [31:0] size, int a, output logic [31:0] granted);
			longint unsigned al, s, len, adj, need, total;
			int slot;
			granted = '0;
			if (size == 0)
				return STAT_NOFIT;
			slot = -1;
			for (int i = 0; i < MAX_ALLOCS; i++)
				if (!rec_live[i] && slot < 0)
					slot = i;
			if (slot < 0)
				return STAT_FULL;
			al = 64'd1 << a;
			for (int i = 0; i < seg_n; i++) begin
				s = seg_s[i];
				len = seg_l[i];
				adj = (al - (s & (al - 1))) & (al - 1);
				if (adj < HEADER_BYTES) begin
					need = HEADER_BYTES - adj;
					adj += ((need + al - 1) >> a) << a;
				end
				total = size + adj;
				if (len < total)
					continue;
				if (len - total <= HEADER_BYTES) begin
					total = len;
					drop_segment(i);
				end else begin
					seg_s[i] = s + total;
					seg_l[i] = len - total;
				end
				granted = s + adj;
				rec_addr[slot] = granted;
				rec_len[slot] = total;
				rec_adj[slot] = adj[7:0];
				rec_live[slot] = 1'b1;
				used_bytes = used_bytes + total[31:0];
				live_n++;
				return STAT_OK;
			end
			return STAT_NOFIT;
		endfunction

		function status_t release_block(logic [31:0] addr);
			logic [31:0] start, size, stop;
			bit mprev, mnext;
			int r, p;
			r = -1;
			for (int i = 0; i < MAX_ALLOCS; i++)
				if (r < 0 && rec_live[i] && rec_addr[i] == addr)
					r = i;
			if (r < 0)
				return STAT_UNKNOWN;
			start = addr - {24'd0, rec_adj[r]};
			size = rec_len[r];
			stop = start + size;
			p = 0;
			while (p < seg_n && seg_s[p] < stop)
				p++;
			mprev = p > 0 && (seg_s[p - 1] + seg_l[p - 1]) == start;
			mnext = p < seg_n && seg_s[p] == stop;
			if (mprev && mnext) begin
				seg_l[p - 1] = seg_l[p - 1] + size + seg_l[p];
				drop_segment(p);
			end else if (mprev) begin
				seg_l[p - 1] = seg_l[p - 1] + size;
			end else if (mnext) begin
				seg_s[p] = start;
				seg_l[p] = seg_l[p] + size;
			end else begin
				if (seg_n >= MAX_SEGMENTS)
					return STAT_FULL;
				for (int i = seg_n; i > p; i--) begin
					seg_s[i] = seg_s[i - 1];
					seg_l[i] = seg_l[i - 1];
				end
				seg_s[p] = start;
				seg_l[p] = size;
				seg_n++;
			end
			rec_live[r] = 1'b0;
			used_bytes = used_bytes - size;
			if (live_n > 0)
				live_n--;
			return STAT_OK;
		endfunction

		function void note_request(logic op, logic [31:0] size, logic [2:0] al,
				logic [31:0] addr);
			outcome_t o;
			logic [31:0] g;
			if (op == OP_ALLOC)
				o.status = grant(size, al, g);
			else begin
				o.status = release_block(addr);
				g = '0;
			end
			o.granted = (o.status == STAT_OK) ? g : '0;
			o.used = used_bytes;
			o.live = live_n[5:0];
			outcome_q.push_back(o);
		endfunction

		function void check_response(addr_t g, status_t st, len_t used, live_t live);
			outcome_t o;
			if (outcome_q.size() == 0) begin
				$display("%0t: unexpected transfer granted=%h status=%0d", $time, g, st);
				errors++;
				return;
			end
			o = outcome_q.pop_front();
			if (g !== o.granted) begin
				$display("%0t: granted_address exp %h got %h", $time, o.granted, g);
				errors++;
			end
			if (st !== o.status) begin
				$display("%0t: status exp %0d got %0d", $time, o.status, st);
				errors++;
			end
			if (used !== o.used) begin
				$display("%0t: bytes_in_use exp %h got %h", $time, o.used, used);
				errors++;
			end
			if (live !== o.live) begin
				$display("%0t: live_count exp %0d got %0d", $time, o.live, live);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   stall_left;
	bit   quiet;
	int   idle_cycles;
	bit   done;

	ffsa_cfg_if cfg ();
	ffsa_req_if req ();
	ffsa_rsp_if rsp ();

	alloc_scoreboard sb = new();

	first_fit_segment_allocator uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg.sink),
		.req(req.sink),
		.rsp(rsp.source)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		if (rsp.valid && rsp.ready)
			sb.check_response(rsp.granted_address, rsp.status, rsp.bytes_in_use,
				rsp.live_count);
		if (stall_left > 0) begin
			stall_left--;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= quiet || ($urandom_range(0, 99) >= 20);
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready)
				|| !arst_n || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("first_fit_segment_allocator_test NOT OK");
			$finish;
		end
	end

	task automatic send(logic op, logic [31:0] size, logic [2:0] al, logic [31:0] addr);
		if (!quiet && $urandom_range(0, 99) < 20) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.op <= op;
		req.req_size <= size;
		req.align_log2 <= al;
		req.free_address <= addr;
		do
			@(posedge clk);
		while (!req.ready);
		sb.note_request(op, size, al, addr);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
		drain();
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do
			@(posedge clk);
		while (!cfg.ready);
		sb.write_reg(idx, data);
		cfg.valid <= 1'b0;
	endtask

	task automatic set_pool(logic [31:0] b, logic [31:0] n);
		write_reg(REG_POOL_BASE, b);
		write_reg(REG_POOL_BYTES, n);
	endtask

	task automatic free_any();
		logic [31:0] a;
		if (!sb.pick_live(a))
			a = $urandom;
		send(OP_FREE, $urandom, $urandom_range(0, 7), a);
	endtask

	task automatic random_items(int n, bit big);
		int r;
		logic [31:0] size;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				case ($urandom_range(0, 9))
					0: size = 32'd0;
					1: size = $urandom;
					2, 3: size = $urandom_range(65, 1024);
					default: size = $urandom_range(1, 64);
				endcase
				if (big && $urandom_range(0, 2) == 0)
					size = $urandom_range(1, 32'h3000_0000);
				send(OP_ALLOC, size, $urandom_range(0, 7), $urandom);
			end else if (r < 92) begin
				free_any();
			end else begin
				send(OP_FREE, $urandom, $urandom_range(0, 7), $urandom);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		stall_left = 0;
		quiet = 1'b0;
		done = 1'b0;
		idle_cycles = 0;
		cfg.valid = 1'b0;
		cfg.index = REG_POOL_BASE;
		cfg.data = '0;
		req.valid = 1'b0;
		req.op = OP_ALLOC;
		req.req_size = '0;
		req.align_log2 = '0;
		req.free_address = '0;
		rsp.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(OP_ALLOC, 32'd16, 3'd0, 32'd0);
		send(OP_FREE, 32'd0, 3'd0, 32'd0);

		set_pool(32'h0000_1000, 32'h0000_1000);
		send(OP_ALLOC, 32'd0, 3'd0, 32'd0);
		send(OP_ALLOC, 32'd1, 3'd0, 32'd0);
		send(OP_ALLOC, 32'd100, 3'd7, 32'hFFFF_FFFF);
		send(OP_ALLOC, 32'hFFFF_FFFF, 3'd7, 32'd0);
		send(OP_ALLOC, 32'd7, 3'd3, 32'd0);
		send(OP_ALLOC, 32'd24, 3'd2, 32'd0);
		send(OP_FREE, 32'hFFFF_FFFF, 3'd7, 32'h0001_2345);
		send(OP_FREE, 32'd0, 3'd0, 32'h0000_1008);
		send(OP_FREE, 32'd0, 3'd0, 32'h0000_1008);
		send(OP_ALLOC, 32'h0000_0FF0, 3'd0, 32'd0);
		repeat (4) free_any();
		send(OP_ALLOC, 32'h0000_0FF8, 3'd0, 32'd0);
		send(OP_ALLOC, 32'h0000_0FF0, 3'd0, 32'd0);
		free_any();

		set_pool(32'h0000_1000, 32'h0000_1000);
		for (int i = 0; i < 33; i++)
			send(OP_ALLOC, 32'd8, 3'd0, 32'd0);
		for (int i = 0; i < 32; i += 2)
			send(OP_FREE, 32'd0, 3'd0, 32'h0000_1008 + i * 16);
		send(OP_FREE, 32'd0, 3'd0, 32'h0000_1008 + 31 * 16);
		repeat (20) free_any();

		set_pool(32'h0000_1000, 32'h0000_1000);
		random_items(60, 1'b0);
		stall_left = 300;
		random_items(30, 1'b0);
		drain();
		quiet = 1'b1;
		random_items(100, 1'b0);
		quiet = 1'b0;
		random_items(80, 1'b0);

		set_pool(32'h0000_0000, 32'h0000_0000);
		random_items(15, 1'b0);
		set_pool(32'h0000_0040, 32'h0000_0005);
		random_items(15, 1'b0);
		set_pool(32'hFFFF_F800, 32'h0000_1000);
		random_items(70, 1'b0);
		set_pool(32'h0000_0000, 32'hFFFF_FFFF);
		random_items(60, 1'b1);
		set_pool(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		random_items(30, 1'b1);

		drain();
		done = 1'b1;
		if (sb.errors == 0 && sb.pending() == 0)
			$display("first_fit_segment_allocator_test OK");
		else
			$display("first_fit_segment_allocator_test NOT OK");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/ffsa_pkg.sv
hdl/ffsa_if.sv
hdl/ffsa_fit.sv
hdl/ffsa_seg_table.sv
hdl/first_fit_segment_allocator.sv
tb/first_fit_segment_allocator_test.sv
